/* hdl/bba_pkg.sv */
// Shared types and constants for the block bitmap allocator.
// No dependencies; used by block_bitmap_allocator_top.
package bba_pkg;

   localparam int BLK_W    = 12;   // block number and allocated index
   localparam int CFG_W    = 13;   // total_blocks register
   localparam int STATUS_W = 2;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK          = 2'd0,
      ST_FULL        = 2'd1,
      ST_DOUBLE_FREE = 2'd2,
      ST_RANGE       = 2'd3
   } status_type;

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_SCAN  = 6'b000100,
      S_SEEK  = 6'b001000,
      S_CHECK = 6'b010000,
      S_PUSH  = 6'b100000
   } state_type;

endpackage

/* hdl/block_bitmap_allocator_top.sv */
// First-fit free-block bitmap allocator, top level.
// Depends on bba_pkg; holds the bitmap memory and its sequencer.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    req_opcode, req_block_number
//   rsp      out        rsp_valid/stall    rsp_allocated_block, rsp_status
//   csr      in         csr_we             csr_wdata (total_blocks)
//
// An allocate reads one bitmap word per cycle from word 0 up, through S_SCAN and then
// S_PUSH to the response register; it reads at most ceil(MAX_BLOCKS / WORD_BITS)
// words, 64 at the defaults. A free steps through S_SEEK to the block's word, then
// S_CHECK and S_PUSH; an out-of-range free goes from S_IDLE straight to S_PUSH.
// After reset a clearing pass writes every word to zero, with req_stall held high.
// A held response does not stop the next transaction being
// taken; only its own result waits for the output register.
module block_bitmap_allocator_top #(
   parameter int MAX_BLOCKS = 4096,
   parameter int WORD_BITS  = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_opcode,
   input  logic [bba_pkg::BLK_W-1:0]     req_block_number,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [bba_pkg::BLK_W-1:0]     rsp_allocated_block,
   output logic [bba_pkg::STATUS_W-1:0]  rsp_status,
   input  logic                          csr_we,
   input  logic [bba_pkg::CFG_W-1:0]     csr_wdata
);

   localparam int NUM_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int SPAN_W    = $clog2((NUM_WORDS + 1) * WORD_BITS) + 1;
   localparam int CNT_W     = (SPAN_W > bba_pkg::CFG_W) ? SPAN_W : bba_pkg::CFG_W;

   // bitmap memory
   logic [WORD_BITS-1:0] mem_ff [NUM_WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_waddr;
   logic [WORD_BITS-1:0] mem_wdata;
   logic [ADDR_W-1:0]    mem_raddr;

   bba_pkg::state_type   state_ff, state_in;
   logic [ADDR_W-1:0]    clr_ff, clr_in;
   logic [ADDR_W-1:0]    word_ff, word_in;
   logic [CNT_W-1:0]     base_ff, base_in;
   logic [bba_pkg::BLK_W-1:0] blk_ff, blk_in;
   logic [bba_pkg::CFG_W-1:0] total_ff;
   logic [bba_pkg::BLK_W-1:0] res_blk_ff, res_blk_in;
   bba_pkg::status_type  res_status_ff, res_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [bba_pkg::BLK_W-1:0] rsp_blk_ff, rsp_blk_in;
   bba_pkg::status_type  rsp_status_ff, rsp_status_in;

   logic [CNT_W-1:0]     total_ext;
   logic [CNT_W-1:0]     eff;
   logic [CNT_W-1:0]     base_end;
   logic [CNT_W-1:0]     lim;
   logic [CNT_W-1:0]     blk_ext;
   logic [CNT_W-1:0]     off_w;
   logic [CNT_W-1:0]     alloc_idx;
   logic [WORD_BITS-1:0] valid_mask;
   logic [WORD_BITS-1:0] free_vec;
   logic [WORD_BITS-1:0] first_free;
   logic [WORD_BITS-1:0] free_bit;
   logic [BIT_W-1:0]     pe;
   logic                 slot_free;
   logic                 accept;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem_ff[mem_raddr];
   end

   assign total_ext = CNT_W'(total_ff);
   assign eff       = (total_ext > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : total_ext;
   assign base_end  = base_ff + CNT_W'(WORD_BITS);
   assign lim       = eff - base_ff;
   assign blk_ext   = CNT_W'(blk_ff);
   assign off_w     = blk_ext - base_ff;
   assign alloc_idx = base_ff + CNT_W'(pe);

   // bits of the current word that lie below the block count
   always_comb begin
      for (int i = 0; i < WORD_BITS; i++) begin
         valid_mask[i] = (eff > base_ff) && (lim > CNT_W'(i));
      end
   end

   assign free_vec   = ~rd_data_ff & valid_mask;
   assign first_free = free_vec & (~free_vec + WORD_BITS'(1));
   assign free_bit   = WORD_BITS'(1) << off_w[BIT_W-1:0];

   always_comb begin
      pe = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (free_vec[i]) begin
            pe = BIT_W'(i);
         end
      end
   end

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != bba_pkg::S_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      word_in       = word_ff;
      base_in       = base_ff;
      blk_in        = blk_ff;
      res_blk_in    = res_blk_ff;
      res_status_in = res_status_ff;
      mem_we        = 1'b0;
      mem_waddr     = word_ff;
      mem_wdata     = rd_data_ff;
      mem_raddr     = '0;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_blk_in    = rsp_blk_ff;
      rsp_status_in = rsp_status_ff;

      case (state_ff)
         bba_pkg::S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(NUM_WORDS - 1)) begin
               state_in = bba_pkg::S_IDLE;
            end
         end
         bba_pkg::S_IDLE: begin
            // word 0 is read here so that a scan has its data next cycle
            mem_raddr = '0;
            if (accept) begin
               word_in    = '0;
               base_in    = '0;
               blk_in     = req_block_number;
               res_blk_in = '0;
               if (req_opcode == bba_pkg::OP_ALLOC) begin
                  state_in = bba_pkg::S_SCAN;
               end else if (CNT_W'(req_block_number) >= eff) begin
                  res_status_in = bba_pkg::ST_RANGE;
                  state_in      = bba_pkg::S_PUSH;
               end else begin
                  state_in = bba_pkg::S_SEEK;
               end
            end
         end
         bba_pkg::S_SCAN: begin
            mem_raddr = word_ff + ADDR_W'(1);
            if (free_vec != '0) begin
               mem_we        = 1'b1;
               mem_wdata     = rd_data_ff | first_free;
               res_blk_in    = alloc_idx[bba_pkg::BLK_W-1:0];
               res_status_in = bba_pkg::ST_OK;
               state_in      = bba_pkg::S_PUSH;
            end else if (eff <= base_end) begin
               res_status_in = bba_pkg::ST_FULL;
               state_in      = bba_pkg::S_PUSH;
            end else begin
               word_in = word_ff + ADDR_W'(1);
               base_in = base_end;
            end
         end
         bba_pkg::S_SEEK: begin
            mem_raddr = word_ff;
            if (blk_ext < base_end) begin
               state_in = bba_pkg::S_CHECK;
            end else begin
               word_in = word_ff + ADDR_W'(1);
               base_in = base_end;
            end
         end
         bba_pkg::S_CHECK: begin
            if ((rd_data_ff & free_bit) == '0) begin
               res_status_in = bba_pkg::ST_DOUBLE_FREE;
            end else begin
               mem_we        = 1'b1;
               mem_wdata     = rd_data_ff & ~free_bit;
               res_status_in = bba_pkg::ST_OK;
            end
            state_in = bba_pkg::S_PUSH;
         end
         bba_pkg::S_PUSH: begin
            // hold the result until the output register is free
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_blk_in    = res_blk_ff;
               rsp_status_in = res_status_ff;
               state_in      = bba_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bba_pkg::S_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bba_pkg::S_CLEAR;
         clr_ff       <= '0;
         total_ff     <= bba_pkg::CFG_W'(4096);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            total_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      word_ff       <= word_in;
      base_ff       <= base_in;
      blk_ff        <= blk_in;
      res_blk_ff    <= res_blk_in;
      res_status_ff <= res_status_in;
      rsp_blk_ff    <= rsp_blk_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_allocated_block = rsp_blk_ff;
   assign rsp_status          = rsp_status_ff;

endmodule

/* tb/sv/tb_block_bitmap_allocator_top.sv */
// Self-checking testbench for block_bitmap_allocator_top: first-fit allocate and free
// transactions with random idling on both channels, checked against a bitmap predictor.
// Depends on bba_pkg and the block_bitmap_allocator_top RTL.
`timescale 1ns / 100ps

module tb_block_bitmap_allocator_top;

   localparam int MAX_BLOCKS   = 4096;
   localparam int RANDOM_ITEMS = 750;
   localparam int DRAIN_CYCLES = 80;      // longest allocate scan plus margin
   localparam int CYCLE_LIMIT  = 500000;
   localparam int LONG_HOLD    = 400;
   localparam int HOLD_AT      = 300;

   typedef struct packed {
      logic                      opcode;
      logic [bba_pkg::BLK_W-1:0] block_number;
   } block_request_type;

   typedef struct packed {
      logic [bba_pkg::BLK_W-1:0] block;
      bba_pkg::status_type       status;
   } alloc_result_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic                         req_opcode = bba_pkg::OP_ALLOC;
   logic [bba_pkg::BLK_W-1:0]    req_block_number = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [bba_pkg::BLK_W-1:0]    rsp_allocated_block;
   logic [bba_pkg::STATUS_W-1:0] rsp_status;
   logic                         csr_we = 1'b0;
   logic [bba_pkg::CFG_W-1:0]    csr_wdata = '0;

   block_request_type pending_q[$];
   alloc_result_type  expected_q[$];

   // predictor state
   bit                        used_map [MAX_BLOCKS];
   logic [bba_pkg::CFG_W-1:0] block_count = bba_pkg::CFG_W'(4096);

   int unsigned failures   = 0;
   int unsigned cycle_count = 0;
   int unsigned req_taken  = 0;
   int unsigned req_gap    = 0;
   bit          req_quiet  = 1'b0;
   int unsigned rsp_taken  = 0;
   int unsigned rsp_wait   = 0;
   bit          rsp_quiet  = 1'b0;
   bit          hold_done  = 1'b0;

   block_bitmap_allocator_top i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_block_number    (req_block_number),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_allocated_block (rsp_allocated_block),
      .rsp_status          (rsp_status),
      .csr_we              (csr_we),
      .csr_wdata           (csr_wdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t timeout after %0d cycles", $time, cycle_count);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // First-fit allocate or free against the predicted bitmap.
   function automatic alloc_result_type predict_outcome(input logic op,
                                                        input logic [bba_pkg::BLK_W-1:0] blk);
      alloc_result_type r;
      int unsigned      span;
      r.block  = '0;
      r.status = bba_pkg::ST_FULL;
      span = (block_count > MAX_BLOCKS) ? MAX_BLOCKS : block_count;
      if (op == bba_pkg::OP_ALLOC) begin
         for (int unsigned b = 0; b < span; b++) begin
            if (!used_map[b]) begin
               used_map[b] = 1'b1;
               r.block     = bba_pkg::BLK_W'(b);
               r.status    = bba_pkg::ST_OK;
               break;
            end
         end
      end else if (blk >= span) begin
         r.status = bba_pkg::ST_RANGE;
      end else if (!used_map[blk]) begin
         r.status = bba_pkg::ST_DOUBLE_FREE;
      end else begin
         used_map[blk] = 1'b0;
         r.status      = bba_pkg::ST_OK;
      end
      return r;
   endfunction

   always @(posedge clock) begin : req_driver
      block_request_type nxt;
      bit                advance;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         advance = !req_valid;
         if (req_valid && !req_stall) begin
            expected_q.push_back(predict_outcome(req_opcode, req_block_number));
            req_taken++;
            if (req_taken % 32 == 0) req_quiet = ($urandom_range(0, 3) == 0);
            req_gap = req_quiet ? 0 : $urandom_range(0, 10);
            advance = 1'b1;
         end
         if (advance) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
               nxt = pending_q.pop_front();
               req_valid        <= 1'b1;
               req_opcode       <= nxt.opcode;
               req_block_number <= nxt.block_number;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      alloc_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               failures++;
               $display("%0t unexpected result: block %0d status %0d", $time,
                        rsp_allocated_block, rsp_status);
            end else begin
               want = expected_q.pop_front();
               if (rsp_allocated_block !== want.block) begin
                  failures++;
                  $display("%0t allocated_block mismatch: expected %0d actual %0d",
                           $time, want.block, rsp_allocated_block);
               end
               if (rsp_status !== want.status) begin
                  failures++;
                  $display("%0t status mismatch: expected %0d actual %0d",
                           $time, want.status, rsp_status);
               end
            end
            rsp_taken++;
            if (rsp_taken % 32 == 0) rsp_quiet = ($urandom_range(0, 3) == 0);
            rsp_wait = rsp_quiet ? 0 : $urandom_range(0, 10);
            // hold off while the sender still has work, so the block backs up into its input
            if (!hold_done && rsp_taken >= HOLD_AT && pending_q.size() > 8) begin
               rsp_wait  = LONG_HOLD;
               hold_done = 1'b1;
            end
         end else if (rsp_wait > 0) begin
            rsp_wait--;
         end
         rsp_stall <= (rsp_wait != 0);
      end
   end

   task automatic queue_request(input logic op, input logic [bba_pkg::BLK_W-1:0] blk);
      block_request_type item;
      item.opcode       = op;
      item.block_number = blk;
      pending_q.push_back(item);
   endtask

   task automatic wait_drained();
      while (pending_q.size() != 0 || req_valid || expected_q.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_block_count(input logic [bba_pkg::CFG_W-1:0] value);
      wait_drained();
      repeat (2) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      block_count = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin : stimulus
      int unsigned               random_items;
      int unsigned               phase_len;
      int unsigned               span;
      int unsigned               alloc_pct;
      logic [bba_pkg::CFG_W-1:0] count_value;
      logic [bba_pkg::BLK_W-1:0] blk;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset count: double free, first fit, hole refill, ignored block number
      queue_request(bba_pkg::OP_FREE, 12'd0);
      queue_request(bba_pkg::OP_ALLOC, 12'd0);
      queue_request(bba_pkg::OP_ALLOC, 12'd0);
      queue_request(bba_pkg::OP_ALLOC, 12'hFFF);
      queue_request(bba_pkg::OP_FREE, 12'hFFF);
      queue_request(bba_pkg::OP_FREE, 12'd1);
      queue_request(bba_pkg::OP_ALLOC, 12'd0);
      queue_request(bba_pkg::OP_FREE, 12'd0);
      queue_request(bba_pkg::OP_FREE, 12'd0);

      // single block: full after one, free just above the count
      write_block_count(bba_pkg::CFG_W'(1));
      queue_request(bba_pkg::OP_ALLOC, 12'd0);
      queue_request(bba_pkg::OP_ALLOC, 12'd0);
      queue_request(bba_pkg::OP_FREE, 12'd0);
      queue_request(bba_pkg::OP_FREE, 12'd1);
      queue_request(bba_pkg::OP_ALLOC, 12'd0);

      // zero count: nothing to allocate, everything out of range
      write_block_count(bba_pkg::CFG_W'(0));
      queue_request(bba_pkg::OP_ALLOC, 12'd0);
      queue_request(bba_pkg::OP_FREE, 12'd0);
      queue_request(bba_pkg::OP_FREE, 12'hFFF);

      // count above the maximum saturates
      write_block_count(bba_pkg::CFG_W'(8191));
      queue_request(bba_pkg::OP_ALLOC, 12'd0);
      queue_request(bba_pkg::OP_FREE, 12'hFFF);

      // lower the count below blocks in use, then raise it again
      write_block_count(bba_pkg::CFG_W'(64));
      repeat (5) queue_request(bba_pkg::OP_ALLOC, 12'd0);
      write_block_count(bba_pkg::CFG_W'(3));
      queue_request(bba_pkg::OP_FREE, 12'd5);
      queue_request(bba_pkg::OP_ALLOC, 12'd0);
      write_block_count(bba_pkg::CFG_W'(4096));
      queue_request(bba_pkg::OP_FREE, 12'd5);

      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       count_value = bba_pkg::CFG_W'(0);
            1:       count_value = bba_pkg::CFG_W'(1);
            2:       count_value = bba_pkg::CFG_W'($urandom_range(4096, 8191));
            3:       count_value = bba_pkg::CFG_W'(64 * $urandom_range(1, 3)
                                                   + $urandom_range(0, 2) - 1);
            default: count_value = bba_pkg::CFG_W'($urandom_range(2, 200));
         endcase
         write_block_count(count_value);
         span      = (count_value > MAX_BLOCKS) ? MAX_BLOCKS : count_value;
         alloc_pct = $urandom_range(35, 80);
         phase_len = $urandom_range(20, 60);
         repeat (phase_len) begin
            if ($urandom_range(0, 9) == 0 || span == 0) begin
               // noise: any block number on either operation
               queue_request(1'($urandom_range(0, 1)), bba_pkg::BLK_W'($urandom));
            end else if ($urandom_range(0, 99) < alloc_pct) begin
               queue_request(bba_pkg::OP_ALLOC, bba_pkg::BLK_W'($urandom));
            end else begin
               // keep most frees near the low end where blocks are in use
               if (span > 256 && $urandom_range(0, 3) != 0)
                  blk = bba_pkg::BLK_W'($urandom_range(0, 255));
               else
                  blk = bba_pkg::BLK_W'($urandom_range(0, span - 1));
               queue_request(bba_pkg::OP_FREE, blk);
            end
            random_items++;
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_q.size() != 0) begin
         failures++;
         $display("%0t %0d results never arrived", $time, expected_q.size());
      end
      if (failures == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
